// ===== hw/rtl/fa_lru_pkg.sv =====
// ----------------------------------------------------------------------------
// fa_lru_pkg
// Shared types and fixed field widths for the fully associative LRU lookup.
// ----------------------------------------------------------------------------
package fa_lru_pkg;

    localparam int ADDR_W    = 32;
    localparam int LINE_W    = 3;
    localparam int TAG_OUT_W = 27;
    localparam int CNT_W     = 32;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 96;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } ctrl_state_t;

    // search record flags carried cell to cell with a probe
    typedef struct packed {
        logic valid;
        logic hit;
        logic free;
        logic min_set;
    } scan_flags_t;

    // line update broadcast to all cells
    typedef struct packed {
        logic en;
        logic fill;
    } upd_ctrl_t;

endpackage

// ===== hw/rtl/fa_lru_cell.sv =====
// ----------------------------------------------------------------------------
// fa_lru_cell
// One cache line: valid mark, tag and recency rank. Merges the line into the
// passing search record and applies the broadcast recency and fill update.
// ----------------------------------------------------------------------------
module fa_lru_cell #(
    parameter int LINES    = 8,
    parameter int TAG_BITS = 27,
    parameter int IDX      = 0,
    localparam int LW      = $clog2(LINES)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fa_lru_pkg::scan_flags_t in_flags,
    input  logic [TAG_BITS-1:0]     in_tag,
    input  logic [LW-1:0]           in_pick_line,
    input  logic [LW-1:0]           in_pick_rank,
    input  logic [LW-1:0]           in_min_line,
    input  logic [LW-1:0]           in_min_rank,
    input  logic [TAG_BITS-1:0]     in_min_tag,
    output fa_lru_pkg::scan_flags_t out_flags,
    output logic [TAG_BITS-1:0]     out_tag,
    output logic [LW-1:0]           out_pick_line,
    output logic [LW-1:0]           out_pick_rank,
    output logic [LW-1:0]           out_min_line,
    output logic [LW-1:0]           out_min_rank,
    output logic [TAG_BITS-1:0]     out_min_tag,
    input  fa_lru_pkg::upd_ctrl_t   upd,
    input  logic [LW-1:0]           upd_line,
    input  logic [LW-1:0]           upd_rank,
    input  logic [TAG_BITS-1:0]     upd_tag
);
    import fa_lru_pkg::*;

    localparam logic [LW-1:0] MY_LINE  = LW'(IDX);
    localparam logic [LW-1:0] TOP_RANK = LW'(LINES - 1);

    logic                valid_reg, valid_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [LW-1:0]       rank_reg, rank_next;

    scan_flags_t         flags_reg, flags_next;
    logic [TAG_BITS-1:0] ptag_reg;
    logic [LW-1:0]       pick_line_reg, pick_line_next;
    logic [LW-1:0]       pick_rank_reg, pick_rank_next;
    logic [LW-1:0]       min_line_reg, min_line_next;
    logic [LW-1:0]       min_rank_reg, min_rank_next;
    logic [TAG_BITS-1:0] min_tag_reg, min_tag_next;

    always_comb begin
        flags_next     = in_flags;
        pick_line_next = in_pick_line;
        pick_rank_next = in_pick_rank;
        min_line_next  = in_min_line;
        min_rank_next  = in_min_rank;
        min_tag_next   = in_min_tag;
        if (!in_flags.hit && valid_reg && (tag_reg == in_tag)) begin
            flags_next.hit = 1'b1;
            pick_line_next = MY_LINE;
            pick_rank_next = rank_reg;
        end else if (!in_flags.hit && !in_flags.free && !valid_reg) begin
            flags_next.free = 1'b1;
            pick_line_next  = MY_LINE;
            pick_rank_next  = rank_reg;
        end
        if (!in_flags.min_set || (rank_reg < in_min_rank)) begin
            flags_next.min_set = 1'b1;
            min_line_next      = MY_LINE;
            min_rank_next      = rank_reg;
            min_tag_next       = tag_reg;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        rank_next  = rank_reg;
        if (upd.en) begin
            if (upd_line == MY_LINE) begin
                rank_next = TOP_RANK;
                if (upd.fill) begin
                    valid_next = 1'b1;
                    tag_next   = upd_tag;
                end
            end else if (rank_reg > upd_rank) begin
                rank_next = rank_reg - LW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tag_reg   <= '0;
            rank_reg  <= MY_LINE;
            flags_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            tag_reg   <= tag_next;
            rank_reg  <= rank_next;
            if (in_flags.valid) begin
                flags_reg <= flags_next;
            end else begin
                flags_reg.valid <= 1'b0;
            end
        end
    end

    // hold the record once the probe has passed
    always_ff @(posedge aclk) begin
        if (in_flags.valid) begin
            ptag_reg      <= in_tag;
            pick_line_reg <= pick_line_next;
            pick_rank_reg <= pick_rank_next;
            min_line_reg  <= min_line_next;
            min_rank_reg  <= min_rank_next;
            min_tag_reg   <= min_tag_next;
        end
    end

    assign out_flags     = flags_reg;
    assign out_tag       = ptag_reg;
    assign out_pick_line = pick_line_reg;
    assign out_pick_rank = pick_rank_reg;
    assign out_min_line  = min_line_reg;
    assign out_min_rank  = min_rank_reg;
    assign out_min_tag   = min_tag_reg;

endmodule

// ===== hw/rtl/fully_assoc_lru_cache_lookup.sv =====
// ----------------------------------------------------------------------------
// fully_assoc_lru_cache_lookup
// Fully associative tag lookup with true LRU replacement over a row of cells.
// An accepted address walks the row of cells, one register per line; the write
// state then applies the rank/fill update and registers the result word, waiting
// while the output holds an unaccepted word. A new address is taken only in idle.
// Reset: all lines invalid, rank of each line equals its number, counts zero.
// ----------------------------------------------------------------------------
module fully_assoc_lru_cache_lookup #(
    parameter int LINES       = 8,
    parameter int OFFSET_BITS = 5,
    parameter int ADDR_BITS   = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // address
    input  logic [fa_lru_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // hit, line_used, evicted, evicted_tag, hit_tally, access_tally
    output logic [fa_lru_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready
);
    import fa_lru_pkg::*;

    localparam int LW       = $clog2(LINES);
    localparam int TAG_BITS = ADDR_BITS - OFFSET_BITS;

    ctrl_state_t state_reg, state_next;

    logic [ADDR_BITS+ADDR_W-1:0] addr_ext;
    logic [ADDR_BITS-1:0]        addr_use;
    logic [TAG_BITS-1:0]         probe_tag;

    scan_flags_t         c_flags     [0:LINES];
    logic [TAG_BITS-1:0] c_tag       [0:LINES];
    logic [LW-1:0]       c_pick_line [0:LINES];
    logic [LW-1:0]       c_pick_rank [0:LINES];
    logic [LW-1:0]       c_min_line  [0:LINES];
    logic [LW-1:0]       c_min_rank  [0:LINES];
    logic [TAG_BITS-1:0] c_min_tag   [0:LINES];

    upd_ctrl_t           upd;
    logic [LW-1:0]       upd_line;
    logic [LW-1:0]       upd_rank;
    logic                out_free;
    logic                take;
    logic                res_hit;
    logic                res_evicted;
    logic [TAG_BITS-1:0] res_tag;
    logic [LW+LINE_W-1:0]        line_ext;
    logic [TAG_BITS+TAG_OUT_W-1:0] tag_ext;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [CNT_W-1:0]     hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]     acc_cnt_reg, acc_cnt_next;

    assign addr_ext  = {{ADDR_BITS{1'b0}}, s_tdata};
    assign addr_use  = addr_ext[ADDR_BITS-1:0];
    assign probe_tag = addr_use[ADDR_BITS-1:OFFSET_BITS];

    assign take = s_tvalid && s_tready;

    assign c_flags[0]     = scan_flags_t'{valid: take, hit: 1'b0, free: 1'b0, min_set: 1'b0};
    assign c_tag[0]       = probe_tag;
    assign c_pick_line[0] = '0;
    assign c_pick_rank[0] = '0;
    assign c_min_line[0]  = '0;
    assign c_min_rank[0]  = '0;
    assign c_min_tag[0]   = '0;

    for (genvar i = 0; i < LINES; i++) begin : g_cell
        fa_lru_cell #(
            .LINES    (LINES),
            .TAG_BITS (TAG_BITS),
            .IDX      (i)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .in_flags      (c_flags[i]),
            .in_tag        (c_tag[i]),
            .in_pick_line  (c_pick_line[i]),
            .in_pick_rank  (c_pick_rank[i]),
            .in_min_line   (c_min_line[i]),
            .in_min_rank   (c_min_rank[i]),
            .in_min_tag    (c_min_tag[i]),
            .out_flags     (c_flags[i+1]),
            .out_tag       (c_tag[i+1]),
            .out_pick_line (c_pick_line[i+1]),
            .out_pick_rank (c_pick_rank[i+1]),
            .out_min_line  (c_min_line[i+1]),
            .out_min_rank  (c_min_rank[i+1]),
            .out_min_tag   (c_min_tag[i+1]),
            .upd           (upd),
            .upd_line      (upd_line),
            .upd_rank      (upd_rank),
            .upd_tag       (c_tag[LINES])
        );
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_SCAN;
            ST_SCAN:  if (c_flags[LINES].valid) state_next = ST_WRITE;
            ST_WRITE: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        upd      = '0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SCAN:  s_tready = 1'b0;
            ST_WRITE: upd.en   = out_free;
            default:  s_tready = 1'b0;
        endcase
        upd.fill = !c_flags[LINES].hit;
    end

    always_comb begin
        res_hit     = c_flags[LINES].hit;
        res_evicted = !c_flags[LINES].hit && !c_flags[LINES].free;
        if (res_evicted) begin
            upd_line = c_min_line[LINES];
            upd_rank = c_min_rank[LINES];
            res_tag  = c_min_tag[LINES];
        end else begin
            upd_line = c_pick_line[LINES];
            upd_rank = c_pick_rank[LINES];
            res_tag  = '0;
        end
        line_ext = {{LINE_W{1'b0}}, upd_line};
        tag_ext  = {{TAG_OUT_W{1'b0}}, res_tag};
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        hit_cnt_next  = hit_cnt_reg;
        acc_cnt_next  = acc_cnt_reg;
        if (upd.en) begin
            m_tvalid_next = 1'b1;
            acc_cnt_next  = acc_cnt_reg + CNT_W'(1);
            hit_cnt_next  = hit_cnt_reg + CNT_W'(res_hit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            hit_cnt_reg  <= '0;
            acc_cnt_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            hit_cnt_reg  <= hit_cnt_next;
            acc_cnt_reg  <= acc_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.en) begin
            m_tdata_reg <= {acc_cnt_next, hit_cnt_next, tag_ext[TAG_OUT_W-1:0],
                            res_evicted, line_ext[LINE_W-1:0], res_hit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/lru_lookup_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_lookup_checker
// Watches the address and result channels of the fully associative LRU
// lookup. Keeps its own copy of the eight lines (valid, tag, rank) and the
// hit and access counts. Predicts one result word per accepted address and
// compares every accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module lru_lookup_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [fa_lru_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [fa_lru_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    output int                               fail_count,
    output int                               words_pending
);
    import fa_lru_pkg::*;

    localparam int NUM_LINES = 8;
    localparam int OFFSET_W  = 5;

    typedef struct {
        logic                 hit;
        logic [LINE_W-1:0]    line_used;
        logic                 evicted;
        logic [TAG_OUT_W-1:0] evicted_tag;
        logic [CNT_W-1:0]     hit_tally;
        logic [CNT_W-1:0]     access_tally;
    } lookup_word_t;

    logic                 line_valid [NUM_LINES];
    logic [TAG_OUT_W-1:0] line_tag   [NUM_LINES];
    logic [LINE_W-1:0]    line_rank  [NUM_LINES];
    logic [CNT_W-1:0]     hits_seen;
    logic [CNT_W-1:0]     accesses_seen;
    lookup_word_t         expected_words [$];
    int                   mismatches;

    function automatic lookup_word_t lru_lookup_predict(input logic [ADDR_W-1:0] addr);
        lookup_word_t         w;
        logic [TAG_OUT_W-1:0] tag;
        logic [LINE_W-1:0]    old_rank;
        int                   used;
        bit                   found;
        tag           = addr[ADDR_W-1:OFFSET_W];
        w             = '{default: '0};
        accesses_seen = accesses_seen + 1'b1;
        found         = 1'b0;
        used          = -1;
        for (int i = 0; i < NUM_LINES; i++) begin
            if (!found && line_valid[i] && line_tag[i] == tag) begin
                found = 1'b1;
                used  = i;
            end
        end
        if (found) begin
            hits_seen = hits_seen + 1'b1;
            w.hit     = 1'b1;
        end else begin
            for (int i = 0; i < NUM_LINES; i++) begin
                if (used < 0 && !line_valid[i]) used = i;
            end
            // no free line: evict the least recent, lowest number on a tie
            if (used < 0) begin
                used = 0;
                for (int i = 1; i < NUM_LINES; i++) begin
                    if (line_rank[i] < line_rank[used]) used = i;
                end
                w.evicted     = 1'b1;
                w.evicted_tag = line_tag[used];
            end
            line_valid[used] = 1'b1;
            line_tag[used]   = tag;
        end
        old_rank = line_rank[used];
        for (int i = 0; i < NUM_LINES; i++) begin
            if (i != used && line_rank[i] > old_rank) line_rank[i] = line_rank[i] - 1'b1;
        end
        line_rank[used] = LINE_W'(NUM_LINES - 1);
        w.line_used    = LINE_W'(used);
        w.hit_tally    = hits_seen;
        w.access_tally = accesses_seen;
        return w;
    endfunction

    function automatic bit field_differs(input string name, input longint unsigned expv,
                                         input longint unsigned actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0h, actual %0h", name, expv, actv);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge aclk) begin
        lookup_word_t exp_w;
        lookup_word_t got_w;
        bit           bad;
        if (!aresetn) begin
            for (int i = 0; i < NUM_LINES; i++) begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_rank[i]  = LINE_W'(i);
            end
            hits_seen     = '0;
            accesses_seen = '0;
            expected_words.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got_w.hit          = m_tdata[0];
                got_w.line_used    = m_tdata[3:1];
                got_w.evicted      = m_tdata[4];
                got_w.evicted_tag  = m_tdata[31:5];
                got_w.hit_tally    = m_tdata[63:32];
                got_w.access_tally = m_tdata[95:64];
                if (expected_words.size() == 0) begin
                    $error("result word with no access pending: %0h", m_tdata);
                    mismatches++;
                end else begin
                    exp_w = expected_words.pop_front();
                    bad   = 1'b0;
                    bad |= field_differs("hit", exp_w.hit, got_w.hit);
                    bad |= field_differs("line_used", exp_w.line_used, got_w.line_used);
                    bad |= field_differs("evicted", exp_w.evicted, got_w.evicted);
                    bad |= field_differs("evicted_tag", exp_w.evicted_tag,
                                         got_w.evicted_tag);
                    bad |= field_differs("hit_tally", exp_w.hit_tally, got_w.hit_tally);
                    bad |= field_differs("access_tally", exp_w.access_tally,
                                         got_w.access_tally);
                    if (bad) mismatches++;
                end
            end
            if (s_tvalid && s_tready) expected_words.push_back(lru_lookup_predict(s_tdata));
        end
        fail_count    <= mismatches;
        words_pending <= expected_words.size();
    end

endmodule

// ===== tb/fully_assoc_lru_cache_lookup_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fully_assoc_lru_cache_lookup_test
// Drives byte addresses into the LRU lookup: a directed pass over fills,
// hits within a line, extreme addresses and evictions, then random accesses
// drawn mostly from a changing working set so hits and LRU evictions are
// frequent. Sender bursts and receiver stalls vary; the checker predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module fully_assoc_lru_cache_lookup_test;
    import fa_lru_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RANDOM_WORDS = 1400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int STALL_START  = 3000;
    localparam int STALL_LEN    = 500;

    localparam logic [ADDR_W-1:0] DIRECTED_ADDRS [19] = '{
        32'h0000_0000, 32'h0000_001F, 32'hFFFF_FFFF, 32'hFFFF_FFE0,
        32'h0000_0020, 32'h0000_0040, 32'h8000_0000, 32'h5555_5555,
        32'hAAAA_AAAA, 32'h0000_0060, 32'h0000_0000, 32'h1234_5678,
        32'hFFFF_FFFF, 32'h0000_0020, 32'h7FFF_FFFF, 32'h5555_5540,
        32'h0000_001F, 32'h8000_001F, 32'hAAAA_AAA0
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    int                   fail_count;
    int                   words_pending;

    fully_assoc_lru_cache_lookup u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    lru_lookup_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: changing stall pattern plus one long hold-off
    initial begin
        int cyc;
        int mode;
        cyc  = 0;
        mode = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 50 == 0) mode = $urandom_range(0, 3);
            if (cyc >= STALL_START && cyc < STALL_START + STALL_LEN) begin
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 0);
                    2: m_tready <= ($urandom_range(0, 9) != 0);
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    int burst_left = 0;

    task automatic send_address(input logic [ADDR_W-1:0] addr);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= addr;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (words_pending != 0);
    endtask

    initial begin
        logic [TAG_OUT_W-1:0] work_tags [16];
        int                   work_size;
        logic [ADDR_W-1:0]    addr;
        work_size = 8;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_ADDRS[i]) send_address(DIRECTED_ADDRS[i]);
        wait_drained();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 100 == 0) begin
                work_size = $urandom_range(4, 14);
                foreach (work_tags[k]) begin
                    case ($urandom_range(0, 9))
                        0: work_tags[k] = '0;
                        1: work_tags[k] = '1;
                        default: work_tags[k] = TAG_OUT_W'($urandom);
                    endcase
                end
            end
            if (n == RANDOM_WORDS / 2) wait_drained();
            if ($urandom_range(0, 99) < 75)
                addr = {work_tags[$urandom_range(0, work_size - 1)], 5'($urandom)};
            else
                addr = $urandom;
            send_address(addr);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fa_lru_pkg.sv
hw/rtl/fa_lru_cell.sv
hw/rtl/fully_assoc_lru_cache_lookup.sv
tb/lru_lookup_checker.sv
tb/fully_assoc_lru_cache_lookup_test.sv
